// ----- src/vtbb_pkg.sv -----
// Shared types and constants for the vertex transform and bounding box block.
package vtbb_pkg;

    localparam int COORD_W   = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 6;
    localparam int NUM_ROWS  = 3;
    localparam int NUM_COLS  = 4;
    localparam int NUM_AXES  = 3;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Axis 0 is x, 1 is y, 2 is z.
    typedef coord_t [NUM_AXES-1:0] point_t;
    typedef coord_t [NUM_COLS-1:0] mat_row_t;
    typedef mat_row_t [NUM_ROWS-1:0] matrix_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_NORMAL = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_C01 = 3'd0,
        REG_ROW0_C23 = 3'd1,
        REG_ROW1_C01 = 3'd2,
        REG_ROW1_C23 = 3'd3,
        REG_ROW2_C01 = 3'd4,
        REG_ROW2_C23 = 3'd5
    } reg_idx_t;

    // One transformed item on its way to the box stage.
    typedef struct packed {
        logic   bound;
        logic   clear;
        point_t pt;
    } vtbb_item_t;

endpackage

// ----- src/vtbb_cfg_regs.sv -----
// Matrix configuration register file.
module vtbb_cfg_regs
    import vtbb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output matrix_t              matrix
);

    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'd1 << FRAC_BITS);
    localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << COORD_W;
    localparam logic [CFG_W-1:0] RESET_VALS [NUM_REGS] =
        '{ONE_LO, '0, ONE_HI, '0, '0, ONE_LO};

    logic [CFG_W-1:0]    cfg_reg [NUM_REGS];
    logic [NUM_REGS-1:0] wr_sel;

    assign cfg_ready = 1'b1;

    // Decode the write; unknown indexes drop the write.
    always_comb
    begin
        wr_sel = '0;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ROW0_C01: wr_sel = 6'b000001;
                REG_ROW0_C23: wr_sel = 6'b000010;
                REG_ROW1_C01: wr_sel = 6'b000100;
                REG_ROW1_C23: wr_sel = 6'b001000;
                REG_ROW2_C01: wr_sel = 6'b010000;
                REG_ROW2_C23: wr_sel = 6'b100000;
                default:      wr_sel = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= RESET_VALS[i];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                if (wr_sel[i])
                begin
                    cfg_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Even column in the low half, odd column in the high half.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                matrix[r][c] = cfg_reg[r * 2 + c / 2][(c % 2) * COORD_W +: COORD_W];
            end
        end
    end

endmodule

// ----- src/vtbb_xform.sv -----
// Input register, product stage and round/saturate stage of the point transform.
module vtbb_xform
    import vtbb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  point_t     in_pt,
    input  logic       finite,
    input  matrix_t    matrix,
    output logic       item_valid,
    output vtbb_item_t item,
    input  logic       item_ready
);

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(66'sd1 <<< (FRAC_BITS - 1));

    // Stage 0: input register
    logic       s0_valid_reg, s0_valid_next;
    logic [1:0] s0_kind_reg;
    logic       s0_fin_reg;
    point_t     s0_pt_reg;

    // Stage 1: products
    logic                     s1_valid_reg, s1_valid_next;
    logic signed [PROD_W-1:0] s1_prod_reg [NUM_ROWS][NUM_AXES];
    logic signed [PROD_W-1:0] s1_prod_next [NUM_ROWS][NUM_AXES];
    logic                     s1_xform_reg, s1_xform_next;
    logic                     s1_bound_reg, s1_bound_next;
    logic                     s1_clear_reg, s1_clear_next;
    point_t                   s1_pt_reg;

    // Stage 2: finished point
    logic       s2_valid_reg, s2_valid_next;
    vtbb_item_t s2_item_reg, s2_item_next;

    logic s0_free, s1_free, s2_free;

    logic signed [SUM_W-1:0] acc   [NUM_ROWS];
    logic signed [SUM_W-1:0] shift [NUM_ROWS];
    logic signed [SUM_W-1:0] total [NUM_ROWS];
    point_t                  sat_pt;

    // A stage may load when it is empty or its content moves on.
    assign s2_free  = !s2_valid_reg || item_ready;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_free  = !s0_valid_reg || s1_free;
    assign in_stall = !s0_free;

    assign s0_valid_next = s0_free ? in_valid : s0_valid_reg;
    assign s1_valid_next = s1_free ? s0_valid_reg : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_free)
        begin
            s0_kind_reg <= kind;
            s0_fin_reg  <= finite;
            s0_pt_reg   <= in_pt;
        end
    end

    // Classify the item and form the nine products.
    always_comb
    begin
        s1_xform_next = 1'b0;
        s1_bound_next = 1'b0;
        s1_clear_next = 1'b0;
        case (kind_t'(s0_kind_reg))
            KIND_VERTEX:
            begin
                s1_xform_next = s0_fin_reg;
                s1_bound_next = s0_fin_reg;
            end
            KIND_NORMAL: s1_xform_next = s0_fin_reg;
            KIND_CLEAR:  s1_clear_next = 1'b1;
            default:     s1_xform_next = 1'b0;
        endcase
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                s1_prod_next[r][k] = $signed(matrix[r][k]) * $signed(s0_pt_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && s1_free)
        begin
            s1_prod_reg  <= s1_prod_next;
            s1_xform_reg <= s1_xform_next;
            s1_bound_reg <= s1_bound_next;
            s1_clear_reg <= s1_clear_next;
            s1_pt_reg    <= s0_pt_reg;
        end
    end

    // Sum, round half up, add translation, saturate to 32 bits.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            acc[r] = SUM_W'(s1_prod_reg[r][0]) + SUM_W'(s1_prod_reg[r][1])
                   + SUM_W'(s1_prod_reg[r][2]) + HALF;
            shift[r] = acc[r] >>> FRAC_BITS;
            total[r] = shift[r] + SUM_W'($signed(matrix[r][NUM_COLS-1]));
            if (total[r] > SUM_W'(COORD_MAX))
            begin
                sat_pt[r] = COORD_MAX;
            end
            else if (total[r] < SUM_W'(COORD_MIN))
            begin
                sat_pt[r] = COORD_MIN;
            end
            else
            begin
                sat_pt[r] = total[r][COORD_W-1:0];
            end
        end
        s2_item_next.bound = s1_bound_reg;
        s2_item_next.clear = s1_clear_reg;
        s2_item_next.pt    = s1_xform_reg ? sat_pt : s1_pt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_free)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

// ----- src/vtbb_box.sv -----
// Running bounding box state and the result register.
module vtbb_box
    import vtbb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  vtbb_item_t item,
    output logic       item_ready,
    output logic       out_valid,
    input  logic       out_stall,
    output point_t     out_pt,
    output point_t     out_min,
    output point_t     out_max,
    output logic       out_empty
);

    logic   out_valid_reg, out_valid_next;
    point_t min_reg, min_next;
    point_t max_reg, max_next;
    logic   empty_reg, empty_next;
    point_t out_pt_reg;
    point_t out_min_reg;
    point_t out_max_reg;
    logic   out_empty_reg;
    logic   take;

    assign item_ready = !out_valid_reg || !out_stall;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        min_next       = min_reg;
        max_next       = max_reg;
        empty_next     = empty_reg;
        out_valid_next = item_ready ? item_valid : out_valid_reg;
        if (take)
        begin
            if (item.clear)
            begin
                min_next   = {NUM_AXES{COORD_MAX}};
                max_next   = {NUM_AXES{COORD_MIN}};
                empty_next = 1'b1;
            end
            else if (item.bound)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    if ($signed(item.pt[a]) < $signed(min_reg[a]))
                    begin
                        min_next[a] = item.pt[a];
                    end
                    if ($signed(item.pt[a]) > $signed(max_reg[a]))
                    begin
                        max_next[a] = item.pt[a];
                    end
                end
                empty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            min_reg       <= {NUM_AXES{COORD_MAX}};
            max_reg       <= {NUM_AXES{COORD_MIN}};
            empty_reg     <= 1'b1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            empty_reg     <= empty_next;
        end
    end

    // Result shows the box as it stands after this item.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_pt_reg    <= item.pt;
            out_min_reg   <= min_next;
            out_max_reg   <= max_next;
            out_empty_reg <= empty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pt    = out_pt_reg;
    assign out_min   = out_min_reg;
    assign out_max   = out_max_reg;
    assign out_empty = out_empty_reg;

endmodule

// ----- src/vertex_transform_bounding_box.sv -----
// Top level: affine point transform with a running axis-aligned bounding box.
//
// Use:
//   Input channel (in_valid / in_stall) carries one item per accepted edge:
//   kind (vertex, normal, clear box), a signed fixed-point point and a finite
//   flag. Output channel (out_valid / out_stall) returns one item per input:
//   the transformed (or passed) point plus the box after that item.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) loads
//   the six 64-bit matrix registers; write it only while no item is in flight.
//   cfg_ready is always high; unknown indexes are dropped.
// Path: a result passes the input register, product register, rounded point
//   register and result register, in that order.
// Throughput: one item per cycle while out_stall is low; the nine 32x32
//   products have their own stage; box compare logic feeds the result reg.
// Reset: the matrix returns to identity, the box to empty (min at the largest
//   value, max at the most negative), and the pipeline is cleared to empty.
// Stall: while out_stall is high the result holds; earlier stages keep
//   filling until each holds an item, then in_stall rises.
module vertex_transform_bounding_box
    import vtbb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                kind,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic signed [COORD_W-1:0] in_z,
    input  logic                      finite,
    // output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic signed [COORD_W-1:0] out_z,
    output logic signed [COORD_W-1:0] box_min_x,
    output logic signed [COORD_W-1:0] box_min_y,
    output logic signed [COORD_W-1:0] box_min_z,
    output logic signed [COORD_W-1:0] box_max_x,
    output logic signed [COORD_W-1:0] box_max_y,
    output logic signed [COORD_W-1:0] box_max_z,
    output logic                      box_empty,
    // configuration channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    matrix_t    matrix;
    point_t     in_pt;
    logic       item_valid;
    logic       item_ready;
    vtbb_item_t item;
    point_t     out_pt;
    point_t     out_min;
    point_t     out_max;

    // Pack the coordinates, x in axis 0.
    assign in_pt = {in_z, in_y, in_x};

    vtbb_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .matrix    (matrix)
    );

    // Transform pipeline: input, products, round and saturate.
    vtbb_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .in_pt      (in_pt),
        .finite     (finite),
        .matrix     (matrix),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    // Box update happens as the item enters the result register.
    vtbb_box u_box (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_pt     (out_pt),
        .out_min    (out_min),
        .out_max    (out_max),
        .out_empty  (box_empty)
    );

    assign out_x     = out_pt[0];
    assign out_y     = out_pt[1];
    assign out_z     = out_pt[2];
    assign box_min_x = out_min[0];
    assign box_min_y = out_min[1];
    assign box_min_z = out_min[2];
    assign box_max_x = out_max[0];
    assign box_max_y = out_max[1];
    assign box_max_z = out_max[2];

endmodule

// ----- src/vtbb_checker.sv -----
// Port-level checks for the vertex transform block, bound to the top level.
module vtbb_checker
    import vtbb_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [COORD_W-1:0] out_x,
    input logic signed [COORD_W-1:0] out_y,
    input logic signed [COORD_W-1:0] out_z,
    input logic signed [COORD_W-1:0] box_min_x,
    input logic signed [COORD_W-1:0] box_min_y,
    input logic signed [COORD_W-1:0] box_min_z,
    input logic signed [COORD_W-1:0] box_max_x,
    input logic signed [COORD_W-1:0] box_max_y,
    input logic signed [COORD_W-1:0] box_max_z,
    input logic                      box_empty
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_z) && $stable(box_empty))
        else $error("stalled result changed");

    // With nothing waiting at the output the pipeline must take input.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // An empty box shows its reset corners.
    a_empty_corners: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && box_empty |->
            box_min_x == COORD_MAX && box_min_y == COORD_MAX && box_min_z == COORD_MAX
            && box_max_x == COORD_MIN && box_max_y == COORD_MIN && box_max_z == COORD_MIN)
        else $error("empty box with moved corners");

    // A box holding a vertex is ordered on every axis.
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !box_empty |->
            box_min_x <= box_max_x && box_min_y <= box_max_y && box_min_z <= box_max_z)
        else $error("box minimum above maximum");

endmodule

bind vertex_transform_bounding_box vtbb_checker u_vtbb_checker (.*);
